// ===== hw/rtl/mad_pkg.sv =====
// Shared types and constants of the multichannel averaging decimator.
package mad_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS   = 24;
    localparam int CHAN_BITS     = 3;
    localparam int DIVIDER_BITS  = 12;
    localparam int ACTIVE_BITS   = 4;
    localparam int MAX_RESULTS   = 8;
    localparam int CFG_ADDR_BITS = 3;
    localparam int TDATA_BITS    = 32;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TICK_DIVIDER    = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CLAMP_ENABLE    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ACTIVE_CHANNELS = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RANGE_LOW       = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RANGE_HIGH      = 3'd4;

    // Configuration reset values
    localparam logic [DIVIDER_BITS-1:0]       TICK_DIVIDER_RST = 12'd1;
    localparam logic signed [SAMPLE_BITS-1:0] RANGE_LOW_RST    = 24'sh800000;
    localparam logic signed [SAMPLE_BITS-1:0] RANGE_HIGH_RST   = 24'sh7FFFFF;

    typedef struct packed {
        logic [DIVIDER_BITS-1:0]       tick_divider;
        logic                          clamp_enable;
        logic [ACTIVE_BITS-1:0]        active_channels;
        logic signed [SAMPLE_BITS-1:0] range_low;
        logic signed [SAMPLE_BITS-1:0] range_high;
    } cfg_t;

    // One queued command: a sample update or a window close
    typedef struct packed {
        logic                          is_window;
        logic [CHAN_BITS-1:0]          channel;
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          invalid;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOAD,
        BK_DIV,
        BK_EMIT
    } bk_state_t;

endpackage

// ===== hw/rtl/mad_queue.sv =====
// Short command queue that decouples the front from the back.
module mad_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mad_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output mad_pkg::cmd_t head_cmd,
    output logic          empty
);

    mad_pkg::cmd_t                     slot_reg [mad_pkg::QUEUE_DEPTH];
    logic [mad_pkg::QPTR_BITS-1:0]     wr_ptr_reg;
    logic [mad_pkg::QPTR_BITS-1:0]     rd_ptr_reg;
    logic [mad_pkg::QPTR_BITS:0]       fill_reg;

    assign full     = (fill_reg == (mad_pkg::QPTR_BITS+1)'(mad_pkg::QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== hw/rtl/mad_front.sv =====
// Front part: accepts beats, counts ticks and queues sample and window commands.
module mad_front #(
    parameter int CHANNELS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mad_pkg::cfg_t                       cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_kind,
    input  logic [mad_pkg::CHAN_BITS-1:0]       in_channel,
    input  logic signed [mad_pkg::SAMPLE_BITS-1:0] in_value,
    input  logic                                in_invalid,
    output logic                                push,
    output mad_pkg::cmd_t                       push_cmd,
    input  logic                                queue_full
);

    logic [mad_pkg::DIVIDER_BITS-1:0] tick_reg;
    logic [mad_pkg::DIVIDER_BITS-1:0] tick_next;
    logic [mad_pkg::DIVIDER_BITS-1:0] tick_inc;
    logic [mad_pkg::DIVIDER_BITS-1:0] div_eff;
    logic                             accept;
    logic                             window_done;
    logic                             chan_ok;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Classify the beat
    assign div_eff     = (cfg.tick_divider == '0) ? mad_pkg::DIVIDER_BITS'(1)
                                                  : cfg.tick_divider;
    assign tick_inc    = tick_reg + 1'b1;
    assign window_done = (tick_inc >= div_eff);
    assign chan_ok     = (32'(in_channel) < CHANNELS);

    always_comb
    begin
        tick_next          = tick_reg;
        push               = 1'b0;
        push_cmd.is_window = in_kind;
        push_cmd.channel   = in_channel;
        push_cmd.value     = in_value;
        push_cmd.invalid   = in_invalid;
        if (accept)
        begin
            if (in_kind)
            begin
                tick_next = window_done ? '0 : tick_inc;
                push      = window_done;
            end
            else
            begin
                // drop samples of channels that are not built
                push = chan_ok;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_reg <= '0;
        else
            tick_reg <= tick_next;
    end

endmodule

// ===== hw/rtl/mad_div.sv =====
// Radix-2 restoring divider for signed sums by unsigned counts, truncating toward zero.
module mad_div #(
    parameter int SUM_W = 40,
    parameter int CNT_W = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output logic signed [SUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;
    logic [CNT_W-1:0]  rem_step;

    // One quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign diff     = trial - {1'b0, div_reg};
    assign fits     = (trial >= {1'b0, div_reg});
    assign rem_step = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(SUM_W'(0) - quo_reg) : $signed(quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Load magnitude and shift through the quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            quo_reg <= dividend[SUM_W-1] ? (SUM_W'(0) - SUM_W'(dividend)) : SUM_W'(dividend);
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

endmodule

// ===== hw/rtl/mad_back.sv =====
// Back part: per-channel accumulators, window emission through the divider and clamp.
module mad_back #(
    parameter int CHANNELS   = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mad_pkg::cfg_t                          cfg,
    input  mad_pkg::cmd_t                          head_cmd,
    input  logic                                   queue_empty,
    output logic                                   pop,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [mad_pkg::CHAN_BITS-1:0]          out_channel,
    output logic signed [mad_pkg::SAMPLE_BITS-1:0] out_value,
    output logic                                   out_invalid,
    output logic                                   out_last
);

    localparam int SB      = mad_pkg::SAMPLE_BITS;
    localparam int SUM_W   = SB + COUNT_BITS;
    localparam int CIW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LIM_MAX = (CHANNELS < mad_pkg::MAX_RESULTS) ? CHANNELS
                                                               : mad_pkg::MAX_RESULTS;

    // Channel state
    logic signed [SUM_W-1:0] sum_reg  [CHANNELS];
    logic [COUNT_BITS-1:0]   cnt_reg  [CHANNELS];
    logic signed [SB-1:0]    held_reg [CHANNELS];
    logic                    inv_reg  [CHANNELS];

    // Sequencer
    mad_pkg::bk_state_t                state_reg, state_next;
    logic [mad_pkg::CHAN_BITS-1:0]     idx_reg, idx_next;
    logic [mad_pkg::ACTIVE_BITS-1:0]   lim_reg, lim_next;
    logic signed [SB-1:0]              val_reg, val_next;
    logic                              inval_reg, inval_next;

    // Output register
    logic                              out_valid_reg, out_valid_next;
    logic [mad_pkg::CHAN_BITS-1:0]     out_chan_reg, out_chan_next;
    logic signed [SB-1:0]              out_val_reg, out_val_next;
    logic                              out_inv_reg, out_inv_next;
    logic                              out_last_reg, out_last_next;

    logic [CIW-1:0]                    row;
    logic signed [SUM_W-1:0]           sum_rd;
    logic [COUNT_BITS-1:0]             cnt_rd;
    logic signed [SB-1:0]              held_rd;
    logic                              inv_rd;
    logic                              upd_sample;
    logic                              clr_row;
    logic                              held_we;
    logic                              div_start;
    logic                              div_done;
    logic signed [SUM_W-1:0]           div_quot;
    logic [mad_pkg::ACTIVE_BITS-1:0]   lim_calc;
    logic                              is_last;
    logic signed [SB-1:0]              clamp_hi;
    logic signed [SB-1:0]              clamp_val;
    logic                              out_free;

    // Select the row being worked on
    assign row     = (state_reg == mad_pkg::BK_IDLE) ? CIW'(head_cmd.channel) : CIW'(idx_reg);
    assign sum_rd  = sum_reg[row];
    assign cnt_rd  = cnt_reg[row];
    assign held_rd = held_reg[row];
    assign inv_rd  = inv_reg[row];

    // Saturate the channel count of a window
    assign lim_calc = (cfg.active_channels > mad_pkg::ACTIVE_BITS'(LIM_MAX))
                      ? mad_pkg::ACTIVE_BITS'(LIM_MAX) : cfg.active_channels;
    assign is_last  = (({1'b0, idx_reg} + 1'b1) == lim_reg);

    // Apply the high limit first, then the low limit
    assign clamp_hi  = (val_reg > cfg.range_high) ? cfg.range_high : val_reg;
    assign clamp_val = (clamp_hi < cfg.range_low) ? cfg.range_low : clamp_hi;

    assign out_free  = !out_valid_reg || out_ready;

    mad_div #(
        .SUM_W (SUM_W),
        .CNT_W (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_rd),
        .divisor  (cnt_rd),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Next state and strobes
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        lim_next       = lim_reg;
        val_next       = val_reg;
        inval_next     = inval_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_chan_next  = out_chan_reg;
        out_val_next   = out_val_reg;
        out_inv_next   = out_inv_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        upd_sample     = 1'b0;
        clr_row        = 1'b0;
        held_we        = 1'b0;
        div_start      = 1'b0;
        unique case (state_reg)
            mad_pkg::BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop = 1'b1;
                    if (head_cmd.is_window)
                    begin
                        lim_next = lim_calc;
                        idx_next = '0;
                        if (lim_calc != '0)
                            state_next = mad_pkg::BK_LOAD;
                    end
                    else
                    begin
                        upd_sample = 1'b1;
                    end
                end
            end
            mad_pkg::BK_LOAD:
            begin
                inval_next = inv_rd;
                if (inv_rd)
                begin
                    val_next   = '0;
                    state_next = mad_pkg::BK_EMIT;
                end
                else if (cnt_rd != '0)
                begin
                    div_start  = 1'b1;
                    state_next = mad_pkg::BK_DIV;
                end
                else
                begin
                    val_next   = held_rd;
                    state_next = mad_pkg::BK_EMIT;
                end
            end
            mad_pkg::BK_DIV:
            begin
                if (div_done)
                begin
                    val_next   = div_quot[SB-1:0];
                    held_we    = 1'b1;
                    state_next = mad_pkg::BK_EMIT;
                end
            end
            mad_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_chan_next  = idx_reg;
                    out_inv_next   = inval_reg;
                    out_last_next  = is_last;
                    if (inval_reg || !cfg.clamp_enable)
                        out_val_next = val_reg;
                    else
                        out_val_next = clamp_val;
                    clr_row = 1'b1;
                    if (is_last)
                    begin
                        state_next = mad_pkg::BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = mad_pkg::BK_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = mad_pkg::BK_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mad_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        lim_reg      <= lim_next;
        val_reg      <= val_next;
        inval_reg    <= inval_next;
        out_chan_reg <= out_chan_next;
        out_val_reg  <= out_val_next;
        out_inv_reg  <= out_inv_next;
        out_last_reg <= out_last_next;
    end

    // Update the channel accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c]  <= '0;
                cnt_reg[c]  <= '0;
                held_reg[c] <= '0;
                inv_reg[c]  <= 1'b0;
            end
        end
        else
        begin
            if (upd_sample)
            begin
                if (head_cmd.invalid)
                begin
                    inv_reg[row] <= 1'b1;
                end
                else if (cnt_rd != {COUNT_BITS{1'b1}})
                begin
                    sum_reg[row] <= sum_rd + {{COUNT_BITS{head_cmd.value[SB-1]}},
                                              head_cmd.value};
                    cnt_reg[row] <= cnt_rd + 1'b1;
                end
            end
            if (held_we)
                held_reg[row] <= div_quot[SB-1:0];
            if (clr_row)
            begin
                sum_reg[row] <= '0;
                cnt_reg[row] <= '0;
                inv_reg[row] <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_chan_reg;
    assign out_value   = out_val_reg;
    assign out_invalid = out_inv_reg;
    assign out_last    = out_last_reg;

endmodule

// ===== hw/rtl/multichannel_averaging_decimator_core.sv =====
// Flow: a taken sample beat passes through the command queue into its channel's
//   accumulator; a closing tick beat queues a window that is emitted channel by channel.
// Throughput: one beat per cycle into a 4-entry command queue while it is not full;
//   each active channel with samples and no invalid flag goes through the bit-serial divider.
// Reset: rst_n clears accumulators, held values, tick count and queue at once and
//   loads the configuration defaults; no clearing pass follows.
module multichannel_averaging_decimator_core #(
    parameter int CHANNELS   = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // slave stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [mad_pkg::TDATA_BITS-1:0]       s_axis_tdata,  // channel, sample_value, sample_invalid
    input  logic                                 s_axis_tuser,  // kind
    // master stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [mad_pkg::TDATA_BITS-1:0]       m_axis_tdata,  // out_channel, average_value, out_invalid
    output logic                                 m_axis_tlast,  // last_of_window
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [mad_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [mad_pkg::SAMPLE_BITS-1:0]      cfg_wdata
);

    localparam int SB = mad_pkg::SAMPLE_BITS;
    localparam int CB = mad_pkg::CHAN_BITS;

    mad_pkg::cfg_t            cfg_reg;
    mad_pkg::cmd_t            push_cmd;
    mad_pkg::cmd_t            head_cmd;
    logic                     push;
    logic                     pop;
    logic                     queue_full;
    logic                     queue_empty;
    logic [CB-1:0]            res_channel;
    logic signed [SB-1:0]     res_value;
    logic                     res_invalid;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_divider    <= mad_pkg::TICK_DIVIDER_RST;
            cfg_reg.clamp_enable    <= 1'b1;
            cfg_reg.active_channels <= '0;
            cfg_reg.range_low       <= mad_pkg::RANGE_LOW_RST;
            cfg_reg.range_high      <= mad_pkg::RANGE_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                mad_pkg::CFG_TICK_DIVIDER:
                    cfg_reg.tick_divider <= cfg_wdata[mad_pkg::DIVIDER_BITS-1:0];
                mad_pkg::CFG_CLAMP_ENABLE:
                    cfg_reg.clamp_enable <= cfg_wdata[0];
                mad_pkg::CFG_ACTIVE_CHANNELS:
                    cfg_reg.active_channels <= cfg_wdata[mad_pkg::ACTIVE_BITS-1:0];
                mad_pkg::CFG_RANGE_LOW:
                    cfg_reg.range_low <= $signed(cfg_wdata);
                mad_pkg::CFG_RANGE_HIGH:
                    cfg_reg.range_high <= $signed(cfg_wdata);
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    mad_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_kind    (s_axis_tuser),
        .in_channel (s_axis_tdata[CB-1:0]),
        .in_value   ($signed(s_axis_tdata[CB+SB-1:CB])),
        .in_invalid (s_axis_tdata[CB+SB]),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    mad_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty)
    );

    mad_back #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_cmd    (head_cmd),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_channel (res_channel),
        .out_value   (res_value),
        .out_invalid (res_invalid),
        .out_last    (m_axis_tlast)
    );

    // Pack the result beat, zero padded to whole bytes
    assign m_axis_tdata = {{(mad_pkg::TDATA_BITS - CB - SB - 1){1'b0}},
                           res_invalid, res_value, res_channel};

endmodule
